[rtl/sit_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// sit_pkg
// Shared widths, word types and orientation codes for the segment
// intersection test.
// ============================================================================
package sit_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int SUM_W       = PROD_W + 1;

	typedef logic [1:0] orient_t;

	localparam orient_t ORIENT_COL = 2'd0;
	localparam orient_t ORIENT_POS = 2'd1;
	localparam orient_t ORIENT_NEG = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by_coord;
		coord_t cx_coord;
		coord_t cy_coord;
		coord_t dx_coord;
		coord_t dy_coord;
	} seg_word_t;

	typedef struct packed {
		logic    intersects;
		orient_t orient_c_on_ab;
		orient_t orient_d_on_ab;
		orient_t orient_a_on_cd;
		orient_t orient_b_on_cd;
	} res_word_t;

endpackage

[rtl/sit_seg_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// sit_seg_if
// Valid/ready channel carrying one segment pair word.
// ============================================================================
interface sit_seg_if;
	import sit_pkg::*;

	logic      valid;
	logic      ready;
	seg_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/sit_res_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// sit_res_if
// Valid/ready channel carrying one intersection result word.
// ============================================================================
interface sit_res_if;
	import sit_pkg::*;

	logic      valid;
	logic      ready;
	res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/segment_intersection_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// segment_intersection_test
// Closed segment intersection test with exact orientation codes.
// ============================================================================
// An accepted word is held in the input register until the result register can take
// its outcome. Throughput: one word per cycle while the result side does not stall;
// input register feeds exact cross and dot products, result register holds the outcome.
// Reset clears both stage valid flags; data registers are not reset.
module segment_intersection_test (
	input  logic      clk,
	input  logic      arst_n,
	sit_seg_if.sink   seg,
	sit_res_if.source res
);
	import sit_pkg::*;

	function automatic orient_t orient(input coord_t px, input coord_t py,
	                                   input coord_t qx, input coord_t qy,
	                                   input coord_t rx, input coord_t ry);
		logic signed [DIFF_W-1:0] d1, d2, d3, d4;
		logic signed [PROD_W-1:0] p1, p2;
		logic signed [SUM_W-1:0]  c;
		d1 = DIFF_W'(qy) - DIFF_W'(py);
		d2 = DIFF_W'(rx) - DIFF_W'(qx);
		d3 = DIFF_W'(qx) - DIFF_W'(px);
		d4 = DIFF_W'(ry) - DIFF_W'(qy);
		p1 = PROD_W'(d1) * PROD_W'(d2);
		p2 = PROD_W'(d3) * PROD_W'(d4);
		c  = SUM_W'(p1) - SUM_W'(p2);
		if (c == '0)
			return ORIENT_COL;
		else if (c[SUM_W-1])
			return ORIENT_NEG;
		else
			return ORIENT_POS;
	endfunction

	// (x-u).(w-v) >= 0
	function automatic logic dot_nonneg(input coord_t xx, input coord_t xy,
	                                    input coord_t ux, input coord_t uy,
	                                    input coord_t wx, input coord_t wy,
	                                    input coord_t vx, input coord_t vy);
		logic signed [DIFF_W-1:0] e1, e2, e3, e4;
		logic signed [PROD_W-1:0] p1, p2;
		logic signed [SUM_W-1:0]  s;
		e1 = DIFF_W'(xx) - DIFF_W'(ux);
		e2 = DIFF_W'(wx) - DIFF_W'(vx);
		e3 = DIFF_W'(xy) - DIFF_W'(uy);
		e4 = DIFF_W'(wy) - DIFF_W'(vy);
		p1 = PROD_W'(e1) * PROD_W'(e2);
		p2 = PROD_W'(e3) * PROD_W'(e4);
		s  = SUM_W'(p1) + SUM_W'(p2);
		return !s[SUM_W-1];
	endfunction

	// collinear point X on closed segment U-V
	function automatic logic on_seg(input coord_t xx, input coord_t xy,
	                                input coord_t ux, input coord_t uy,
	                                input coord_t vx, input coord_t vy);
		if (ux == vx && uy == vy)
			return (xx == ux) && (xy == uy);
		return dot_nonneg(xx, xy, ux, uy, vx, vy, ux, uy) &&
		       dot_nonneg(xx, xy, vx, vy, ux, uy, vx, vy);
	endfunction

	seg_word_t seg_s1;
	logic      vld_s1;
	res_word_t res_s2;
	logic      vld_s2;
	logic      adv_s1;
	res_word_t res_d;

	orient_t o1, o2, o3, o4;
	logic    cross_hit;
	logic    touch_hit;

	assign adv_s1    = vld_s1 && (!vld_s2 || res.ready);
	assign seg.ready = !vld_s1 || adv_s1;

	always_comb begin
		o1 = orient(seg_s1.ax, seg_s1.ay, seg_s1.bx, seg_s1.by_coord,
		            seg_s1.cx_coord, seg_s1.cy_coord);
		o2 = orient(seg_s1.ax, seg_s1.ay, seg_s1.bx, seg_s1.by_coord,
		            seg_s1.dx_coord, seg_s1.dy_coord);
		o3 = orient(seg_s1.cx_coord, seg_s1.cy_coord, seg_s1.dx_coord, seg_s1.dy_coord,
		            seg_s1.ax, seg_s1.ay);
		o4 = orient(seg_s1.cx_coord, seg_s1.cy_coord, seg_s1.dx_coord, seg_s1.dy_coord,
		            seg_s1.bx, seg_s1.by_coord);
		cross_hit = (o1 != o2) && (o3 != o4);
		touch_hit =
			(o1 == ORIENT_COL && on_seg(seg_s1.cx_coord, seg_s1.cy_coord,
			                            seg_s1.ax, seg_s1.ay,
			                            seg_s1.bx, seg_s1.by_coord)) ||
			(o2 == ORIENT_COL && on_seg(seg_s1.dx_coord, seg_s1.dy_coord,
			                            seg_s1.ax, seg_s1.ay,
			                            seg_s1.bx, seg_s1.by_coord)) ||
			(o3 == ORIENT_COL && on_seg(seg_s1.ax, seg_s1.ay,
			                            seg_s1.cx_coord, seg_s1.cy_coord,
			                            seg_s1.dx_coord, seg_s1.dy_coord)) ||
			(o4 == ORIENT_COL && on_seg(seg_s1.bx, seg_s1.by_coord,
			                            seg_s1.cx_coord, seg_s1.cy_coord,
			                            seg_s1.dx_coord, seg_s1.dy_coord));
		res_d.intersects     = cross_hit || touch_hit;
		res_d.orient_c_on_ab = o1;
		res_d.orient_d_on_ab = o2;
		res_d.orient_a_on_cd = o3;
		res_d.orient_b_on_cd = o4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (seg.ready)
				vld_s1 <= seg.valid;
			if (adv_s1)
				vld_s2 <= 1'b1;
			else if (res.ready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && seg.ready)
			seg_s1 <= seg.data;
		if (adv_s1)
			res_s2 <= res_d;
	end

	assign res.valid = vld_s2;
	assign res.data  = res_s2;

endmodule

[sim/sit_verdict_check.sv]
`timescale 1ns / 1ps
// ============================================================================
// sit_verdict_check
// Watches the segment and result channels of the intersection test. Each
// accepted segment word gets its verdict computed here with exact 64-bit
// cross and dot products. Each result word is compared field by field with
// the oldest pending verdict. The mismatch count and the number of verdicts
// still pending go back to the bench top.
// ============================================================================
module sit_verdict_check
	import sit_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sit_seg_if   seg,
	sit_res_if   res,
	output int   errors,
	output int   pending
);

	res_word_t verdicts[$];
	int        fail_count  = 0;
	int        outstanding = 0;

	assign errors  = fail_count;
	assign pending = outstanding;

	function automatic orient_t turn_code(longint px, longint py, longint qx, longint qy,
					      longint rx, longint ry);
		longint area;
		area = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		if (area == 0)
			return ORIENT_COL;
		else if (area > 0)
			return ORIENT_POS;
		return ORIENT_NEG;
	endfunction

	// collinear point X on closed segment U-V; a point segment only holds itself
	function automatic bit lies_on(longint xx, longint xy, longint ux, longint uy,
				       longint vx, longint vy);
		if (ux == vx && uy == vy)
			return xx == ux && xy == uy;
		return ((xx - ux) * (vx - ux) + (xy - uy) * (vy - uy) >= 0) &&
		       ((xx - vx) * (ux - vx) + (xy - vy) * (uy - vy) >= 0);
	endfunction

	function automatic res_word_t intersect_verdict(seg_word_t w);
		longint    x1, y1, x2, y2, x3, y3, x4, y4;
		res_word_t r;
		x1 = w.ax;
		y1 = w.ay;
		x2 = w.bx;
		y2 = w.by_coord;
		x3 = w.cx_coord;
		y3 = w.cy_coord;
		x4 = w.dx_coord;
		y4 = w.dy_coord;
		r.orient_c_on_ab = turn_code(x1, y1, x2, y2, x3, y3);
		r.orient_d_on_ab = turn_code(x1, y1, x2, y2, x4, y4);
		r.orient_a_on_cd = turn_code(x3, y3, x4, y4, x1, y1);
		r.orient_b_on_cd = turn_code(x3, y3, x4, y4, x2, y2);
		if (r.orient_c_on_ab != r.orient_d_on_ab && r.orient_a_on_cd != r.orient_b_on_cd)
			r.intersects = 1'b1;
		else
			r.intersects =
				(r.orient_c_on_ab == ORIENT_COL && lies_on(x3, y3, x1, y1, x2, y2)) ||
				(r.orient_d_on_ab == ORIENT_COL && lies_on(x4, y4, x1, y1, x2, y2)) ||
				(r.orient_a_on_cd == ORIENT_COL && lies_on(x1, y1, x3, y3, x4, y4)) ||
				(r.orient_b_on_cd == ORIENT_COL && lies_on(x2, y2, x3, y3, x4, y4));
		return r;
	endfunction

	function automatic int field_miss(string name, int want, int got);
		if (want == got)
			return 0;
		$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk) begin : watch
		res_word_t want;
		int        bad;
		bad = 0;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (verdicts.size() == 0) begin
					bad++;
					$display("%0t: result word expected none actual %h", $time, res.data);
				end else begin
					want = verdicts.pop_front();
					bad += field_miss("intersects", want.intersects, res.data.intersects);
					bad += field_miss("orient_c_on_ab", want.orient_c_on_ab,
							  res.data.orient_c_on_ab);
					bad += field_miss("orient_d_on_ab", want.orient_d_on_ab,
							  res.data.orient_d_on_ab);
					bad += field_miss("orient_a_on_cd", want.orient_a_on_cd,
							  res.data.orient_a_on_cd);
					bad += field_miss("orient_b_on_cd", want.orient_b_on_cd,
							  res.data.orient_b_on_cd);
				end
			end
			if (seg.valid && seg.ready)
				verdicts.push_back(intersect_verdict(seg.data));
		end
		fail_count  <= fail_count + bad;
		outstanding <= verdicts.size();
	end

endmodule

[sim/segment_intersection_test_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// segment_intersection_test_test
// Bench top for the segment intersection test. Sends directed segment pairs
// (extremes, crossings, touching and collinear cases, point segments), then
// random pairs biased toward collinear, shared-endpoint and degenerate
// shapes, with random gaps and stalls on both channels. The checker beside
// the block predicts and compares; this module gives the verdict.
// ============================================================================
module segment_intersection_test_test;
	import sit_pkg::*;

	localparam int RANDOM_WORDS = 1700;
	localparam int LIMIT        = 300000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   calm   = 1'b0;
	int   cycle_count = 0;
	int   fail_total;
	int   open_count;

	sit_seg_if seg_ch ();
	sit_res_if res_ch ();

	segment_intersection_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg_ch),
		.res    (res_ch)
	);

	sit_verdict_check verdict_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.seg     (seg_ch),
		.res     (res_ch),
		.errors  (fail_total),
		.pending (open_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int spread(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic send_pair(input int ax_v, input int ay_v, input int bx_v, input int by_v,
				 input int cx_v, input int cy_v, input int dx_v, input int dy_v);
		seg_word_t w;
		int        gap;
		w.ax       = coord_t'(ax_v);
		w.ay       = coord_t'(ay_v);
		w.bx       = coord_t'(bx_v);
		w.by_coord = coord_t'(by_v);
		w.cx_coord = coord_t'(cx_v);
		w.cy_coord = coord_t'(cy_v);
		w.dx_coord = coord_t'(dx_v);
		w.dy_coord = coord_t'(dy_v);
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			seg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_ch.valid <= 1'b1;
		seg_ch.data  <= w;
		@(posedge clk);
		while (!seg_ch.ready) @(posedge clk);
	endtask

	// result side
	initial begin : drain
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int px[4];
		int py[4];
		int kk[4];
		int kind, base_x, base_y, ux, uy, s, d;
		seg_ch.valid = 1'b0;
		seg_ch.data  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
		send_pair(0, 0, 10, 10, 5, 5, 20, 20);
		send_pair(0, 0, 4, 4, 5, 5, 9, 9);
		send_pair(0, 0, 4, 4, 4, 4, 9, 9);
		send_pair(0, 0, 4, 0, 4, 0, 4, 7);
		send_pair(0, 0, 10, 0, 5, 0, 5, 5);
		send_pair(0, 0, 10, 0, 0, 1, 10, 1);
		send_pair(0, 0, 10, 0, 11, -5, 11, 5);
		send_pair(0, 0, 10, 10, 3, 3, 3, 3);
		send_pair(0, 0, 10, 10, 12, 12, 12, 12);
		send_pair(5, 5, 5, 5, 0, 0, 10, 10);
		send_pair(1, 2, 1, 2, 3, 4, 3, 4);
		send_pair(0, 0, 10, 10, 3, 4, 3, 4);
		send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
		send_pair(-32768, -32768, 32767, 32767, -32767, -32767, 32766, 32766);
		send_pair(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768);
		send_pair(0, 0, 20, 0, 15, 0, 5, 0);
		send_pair(7, -3, 7, 9, 7, 9, 7, 20);
		send_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			kind   = $urandom_range(0, 9);
			base_x = spread(-1000, 1000);
			base_y = spread(-1000, 1000);
			ux     = spread(-20, 20);
			uy     = spread(-20, 20);
			for (int i = 0; i < 4; i++) begin
				kk[i] = spread(-4, 4);
				px[i] = base_x + kk[i] * ux;
				py[i] = base_y + kk[i] * uy;
			end
			case (kind)
				0, 1: begin
					for (int i = 0; i < 4; i++) begin
						px[i] = $urandom_range(0, 65535);
						py[i] = $urandom_range(0, 65535);
					end
				end
				2: begin
					for (int i = 0; i < 4; i++) begin
						px[i] = spread(-8, 8);
						py[i] = spread(-8, 8);
					end
				end
				3: ;
				4: begin
					px[3] = base_x + spread(-60, 60);
					py[3] = base_y + spread(-60, 60);
				end
				5: begin
					for (int i = 0; i < 4; i++) begin
						px[i] = base_x + spread(-200, 200);
						py[i] = base_y + spread(-200, 200);
					end
					s = $urandom_range(2, 3);
					d = $urandom_range(0, 1);
					px[s] = px[d];
					py[s] = py[d];
				end
				6: begin
					s = 2 * $urandom_range(0, 1);
					px[s + 1] = px[s];
					py[s + 1] = py[s];
				end
				7: begin
					for (int i = 0; i < 4; i++) begin
						px[i] = extreme_coord();
						py[i] = extreme_coord();
					end
				end
				default: begin
					for (int i = 0; i < 4; i++) begin
						px[i] = base_x + spread(-200, 200);
						py[i] = base_y + spread(-200, 200);
					end
				end
			endcase
			send_pair(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
		end

		seg_ch.valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_total == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
